@@ hw/rtl/mbe_pkg.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared widths, reset values and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int C_W           = 32;    // width of each part of point c
    localparam int ITER_W        = 16;    // width of the iteration count and limit
    localparam int FRAC_BITS_DEF = 28;    // fraction bits of c and z
    localparam logic [ITER_W-1:0] LIMIT_RST = 16'd1000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // start a point: z = c, count = 0
        logic mul;     // form the squares and the cross product of z
        logic upd;     // z = z*z + c, count + 1
        logic emit;    // copy count and inside flag into the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic at_limit;    // count equals the iteration limit
        logic escape;      // |z|^2 > 4 for the registered products, or a part of z beyond 2 in magnitude
    } t_dp_sts;

endpackage

@@ hw/rtl/mbe_if.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time channel interfaces
// Valid/ready channels for points, results and the iteration limit.
// ----------------------------------------------------------------------------
interface mbe_pt_if;
    logic                               valid;
    logic                               ready;
    logic signed [mbe_pkg::C_W-1:0]     c_real;
    logic signed [mbe_pkg::C_W-1:0]     c_imag;

    modport source (output valid, output c_real, output c_imag, input ready);
    modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface mbe_res_if;
    logic                               valid;
    logic                               ready;
    logic [mbe_pkg::ITER_W-1:0]         iterations;
    logic                               inside_res;

    modport source (output valid, output iterations, output inside_res, input ready);
    modport sink   (input valid, input iterations, input inside_res, output ready);
endinterface

interface mbe_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mbe_pkg::ITER_W-1:0]         iteration_limit;

    modport source (output valid, output iteration_limit, input ready);
    modport sink   (input valid, input iteration_limit, output ready);
endinterface

@@ hw/rtl/mbe_dp.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time datapath
// Holds c, z, the iteration count and the limit; the three products of z are
// registered, and in the next cycle they are tested for escape and z is updated.
// ----------------------------------------------------------------------------
module mbe_dp #(
    parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mbe_pkg::t_dp_cmd                  i_cmd,
    output mbe_pkg::t_dp_sts                  o_sts,
    input  logic                              i_cfg_we,
    input  logic [mbe_pkg::ITER_W-1:0]        i_cfg_limit,
    input  logic signed [mbe_pkg::C_W-1:0]    i_c_real,
    input  logic signed [mbe_pkg::C_W-1:0]    i_c_imag,
    output logic [mbe_pkg::ITER_W-1:0]        o_iterations,
    output logic                              o_inside_res
);
    import mbe_pkg::*;

    // z stays below 2^(C_W-1) + 8 * 2^FRAC_BITS in magnitude.
    localparam int ZW = ((FRAC_BITS + 3 > C_W - 1) ? FRAC_BITS + 3 : C_W - 1) + 3;
    // Multiplier operands only matter while |z| <= 2.
    localparam int MW = FRAC_BITS + 3;
    localparam int PW = 2 * MW;

    localparam logic signed [ZW-1:0] Two    = {{(ZW-1){1'b0}}, 1'b1} << (FRAC_BITS + 1);
    localparam logic signed [ZW-1:0] NegTwo = -Two;
    localparam logic [PW:0]          Thr    = {{PW{1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

    logic signed [C_W-1:0]    r_c_re, r_c_im;
    logic signed [ZW-1:0]     r_z_re, r_z_im;
    logic [ITER_W-1:0]        r_n;
    logic [ITER_W-1:0]        r_limit;
    logic signed [PW-1:0]     r_sq_re, r_sq_im, r_cross;
    logic                     r_big;
    logic [ITER_W-1:0]        r_iterations;
    logic                     r_inside;

    logic signed [MW-1:0]     m_re, m_im;
    logic [PW:0]              mag_sq;
    logic signed [PW:0]       diff, diff_sh;
    logic signed [PW-1:0]     cross_sh;
    logic signed [ZW-1:0]     n_z_re, n_z_im;
    logic signed [ZW-1:0]     c_re_x, c_im_x;

    assign m_re     = r_z_re[MW-1:0];
    assign m_im     = r_z_im[MW-1:0];
    assign mag_sq   = {1'b0, r_sq_re} + {1'b0, r_sq_im};
    assign diff     = {r_sq_re[PW-1], r_sq_re} - {r_sq_im[PW-1], r_sq_im};
    // Arithmetic shifts give the floor of the exact quotient.
    assign diff_sh  = diff >>> FRAC_BITS;
    assign cross_sh = r_cross >>> (FRAC_BITS - 1);
    assign c_re_x   = {{(ZW-C_W){r_c_re[C_W-1]}}, r_c_re};
    assign c_im_x   = {{(ZW-C_W){r_c_im[C_W-1]}}, r_c_im};
    assign n_z_re   = c_re_x + diff_sh[ZW-1:0];
    assign n_z_im   = c_im_x + cross_sh[ZW-1:0];

    assign o_sts.at_limit = (r_n == r_limit);
    assign o_sts.escape   = r_big || (mag_sq > Thr);

    assign o_iterations = r_iterations;
    assign o_inside_res = r_inside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RST;
            r_n     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_limit;
            end
            if (i_cmd.load) begin
                r_n <= '0;
            end else if (i_cmd.upd) begin
                r_n <= r_n + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_c_re <= i_c_real;
            r_c_im <= i_c_imag;
            r_z_re <= {{(ZW-C_W){i_c_real[C_W-1]}}, i_c_real};
            r_z_im <= {{(ZW-C_W){i_c_imag[C_W-1]}}, i_c_imag};
        end else if (i_cmd.upd) begin
            r_z_re <= n_z_re;
            r_z_im <= n_z_im;
        end
        if (i_cmd.mul) begin
            r_sq_re <= m_re * m_re;
            r_sq_im <= m_im * m_im;
            r_cross <= m_re * m_im;
            r_big   <= (r_z_re > Two) || (r_z_re < NegTwo) ||
                       (r_z_im > Two) || (r_z_im < NegTwo);
        end
        if (i_cmd.emit) begin
            r_iterations <= r_n;
            r_inside     <= (r_n == r_limit);
        end
    end

endmodule

@@ hw/rtl/mbe_ctrl.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time controller
// Sequences load, multiply and update steps for one point and owns the
// valid flag of the result register.
// ----------------------------------------------------------------------------
module mbe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pt_valid,
    output logic               o_pt_ready,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    input  mbe_pkg::t_dp_sts   i_sts,
    output mbe_pkg::t_dp_cmd   o_cmd
);
    import mbe_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_UPD,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_res_valid, n_res_valid;
    logic   slot_free;

    assign slot_free   = !r_res_valid || i_res_ready;
    assign o_pt_ready  = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_res_valid = r_res_valid && !i_res_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_pt_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                // The limit is checked before each update, so a limit of
                // zero finishes without any update.
                if (i_sts.at_limit) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_UPD;
                end
            end
            S_UPD: begin
                if (i_sts.escape) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_MUL;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.emit  = 1'b1;
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

endmodule

@@ hw/rtl/mandelbrot_escape_time.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time iteration
// Counts z = z*z + c updates for one point until |z|^2 > 4 or the limit.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                    Transaction when
//  i_pt      in         c_real, c_imag (Q4.28)     i_pt.valid && i_pt.ready
//  o_res     out        iterations, inside_res     o_res.valid && o_res.ready
//  i_cfg     in         iteration_limit            i_cfg.valid && i_cfg.ready
//
//  Each update of a point forms the three products of z in the multipliers and
//  registers them, then forms the new z in the z adders. Synchronous active-low
//  reset sets the limit to 1000 and empties the block. A new point is taken as
//  soon as the previous one has moved into the result register; a stalled result
//  holds the next point in its final step.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time #(
    parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mbe_pt_if.sink   i_pt,
    mbe_res_if.source o_res,
    mbe_cfg_if.sink  i_cfg
);
    import mbe_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign i_cfg.ready = 1'b1;

    mbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pt_valid  (i_pt.valid),
        .o_pt_ready  (i_pt.ready),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mbe_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_limit  (i_cfg.iteration_limit),
        .i_c_real     (i_pt.c_real),
        .i_c_imag     (i_pt.c_imag),
        .o_iterations (o_res.iterations),
        .o_inside_res (o_res.inside_res)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.mul, cmd.upd, cmd.emit}))
        else $error("more than one datapath command at once");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_res.valid || o_res.ready))
        else $error("result register overwritten while still held");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pt.valid && i_pt.ready) |=> !i_pt.ready)
        else $error("second point taken while one is in progress");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_res.valid)
        else $error("result not presented after it was stored");

endmodule
